// ===== rtl/core/frequency_response_multiplier_top_assert.svh =====
// Assertion macros shared by the frequency response multiplier RTL.
`ifndef FREQUENCY_RESPONSE_MULTIPLIER_TOP_ASSERT_SVH
`define FREQUENCY_RESPONSE_MULTIPLIER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define FRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define FRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/frm_pkg.sv =====
// Types and constants shared by the frequency response multiplier modules.
package frm_pkg;

  localparam int BINS_DEF  = 1024;
  localparam int SLOTS     = 4;
  localparam int BIN_W     = 10;
  localparam int BIN_SPAN  = 1 << BIN_W;
  localparam int SMP_W     = 16;
  localparam int COEF_W    = 2 * SMP_W;
  localparam int LANE_W    = 2 * SMP_W + 1;
  localparam int ACC_W     = LANE_W + 2;
  localparam int FRAC_SHIFT = 14;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_JONES_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT = 1'd1;

  localparam logic [2:0] FILTER_COUNT_RST = 3'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_APPLY = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [BIN_W-1:0]        bin;
    logic [1:0]              slot;
    logic [1:0]              pol;
    logic signed [SMP_W-1:0] a_re;
    logic signed [SMP_W-1:0] a_im;
    logic signed [SMP_W-1:0] b_re;
    logic signed [SMP_W-1:0] b_im;
  } frm_in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] out_a_re;
    logic signed [SMP_W-1:0] out_a_im;
    logic signed [SMP_W-1:0] out_b_re;
    logic signed [SMP_W-1:0] out_b_im;
    logic                    saturated;
  } frm_out_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
  } frm_cplx_t;

  typedef struct packed {
    logic signed [LANE_W-1:0] re;
    logic signed [LANE_W-1:0] im;
  } frm_lane_sum_t;

  typedef struct packed {
    logic mem_en;
    logic wr_en;
    logic mul_en;
    logic sum_en;
  } frm_lane_ctl_t;

  typedef struct packed {
    logic acc_en;
    logic out_en;
  } frm_merge_ctl_t;

endpackage

// ===== rtl/core/frm_wrap.sv =====
// Two-stage bin index wrap: bin modulo BINS, by reciprocal multiplication when BINS is below the bin span.
module frm_wrap
  import frm_pkg::*;
#(
  parameter int BINS = BINS_DEF,
  localparam int AW = $clog2(BINS)
) (
  input  logic             clk,
  input  logic             en1,
  input  logic             en2,
  input  logic [BIN_W-1:0] bin,
  output logic [AW-1:0]    addr
);

  logic [BIN_W-1:0] bin1;

  always_ff @(posedge clk) begin
    if (en1) begin
      bin1 <= bin;
    end
  end

  if (BINS < BIN_SPAN) begin : g_wrap
    // With a rounded-up reciprocal the quotient of a 10-bit bin is exact.
    localparam int RW = 2 * BIN_W;
    localparam logic [RW-1:0] RECIP = RW'(((1 << RW) + BINS - 1) / BINS);
    localparam int PW = RW + BIN_W;

    logic [PW-1:0]    prod;
    logic [BIN_W-1:0] quot;
    logic [RW-1:0]    back;
    logic [BIN_W-1:0] rem;

    assign prod = PW'(bin) * PW'(RECIP);

    always_ff @(posedge clk) begin
      if (en1) begin
        quot <= prod[PW-1:RW];
      end
    end

    assign back = RW'(quot) * RW'(BINS);
    assign rem  = bin1 - back[BIN_W-1:0];

    always_ff @(posedge clk) begin
      if (en2) begin
        addr <= rem[AW-1:0];
      end
    end
  end else begin : g_pass
    always_ff @(posedge clk) begin
      if (en2) begin
        addr <= AW'(bin1);
      end
    end
  end

endmodule

// ===== rtl/core/frm_lane.sv =====
// One coefficient slot: its table memory and a pipelined complex multiplier.
module frm_lane
  import frm_pkg::*;
#(
  parameter int BINS = BINS_DEF,
  localparam int AW = $clog2(BINS)
) (
  input  logic          clk,
  input  frm_lane_ctl_t ctl,
  input  logic [AW-1:0] addr,
  input  logic [COEF_W-1:0] wdata,
  input  frm_cplx_t     smp_a,
  input  frm_cplx_t     smp_b,
  input  logic          use_b,
  output frm_lane_sum_t sum
);

  logic [COEF_W-1:0] mem [BINS];
  logic [COEF_W-1:0] rdata;
  frm_cplx_t         coef;
  frm_cplx_t         smp;
  logic signed [2*SMP_W-1:0] rr, ii, ri, ir;

  // Writes and reads share the pipeline slot, so table order follows beat order.
  always_ff @(posedge clk) begin
    if (ctl.mem_en) begin
      if (ctl.wr_en) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

  assign coef.re = rdata[COEF_W-1:SMP_W];
  assign coef.im = rdata[SMP_W-1:0];
  assign smp     = use_b ? smp_b : smp_a;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      rr <= coef.re * smp.re;
      ii <= coef.im * smp.im;
      ri <= coef.im * smp.re;
      ir <= coef.re * smp.im;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      sum.re <= LANE_W'(rr) - LANE_W'(ii);
      sum.im <= LANE_W'(ri) + LANE_W'(ir);
    end
  end

endmodule

// ===== rtl/core/frm_merge.sv =====
// Combines lane products, rounds to Q1.15 and saturates into the result register.
module frm_merge
  import frm_pkg::*;
(
  input  logic           clk,
  input  frm_merge_ctl_t ctl,
  input  logic           jones,
  input  logic [1:0]     sel,
  input  frm_lane_sum_t  lanes [SLOTS],
  output frm_out_t       result
);

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_SHIFT - 1));

  logic signed [ACC_W-1:0] acc_a_re, acc_a_im, acc_b_re, acc_b_im;
  logic [SMP_W:0] q_a_re, q_a_im, q_b_re, q_b_im;

  // Returns the clip flag above the 16-bit value.
  function automatic logic [SMP_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-FRAC_SHIFT-1:0] t;
    t = acc[ACC_W-1:FRAC_SHIFT];
    if (t > (ACC_W-FRAC_SHIFT)'(32767)) begin
      return {1'b1, 16'h7FFF};
    end else if (t < -(ACC_W-FRAC_SHIFT)'(32768)) begin
      return {1'b1, 16'h8000};
    end else begin
      return {1'b0, t[SMP_W-1:0]};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      if (jones) begin
        acc_a_re <= ACC_W'(lanes[0].re) + ACC_W'(lanes[3].re) + ROUND_BIAS;
        acc_a_im <= ACC_W'(lanes[0].im) + ACC_W'(lanes[3].im) + ROUND_BIAS;
        acc_b_re <= ACC_W'(lanes[1].re) + ACC_W'(lanes[2].re) + ROUND_BIAS;
        acc_b_im <= ACC_W'(lanes[1].im) + ACC_W'(lanes[2].im) + ROUND_BIAS;
      end else begin
        acc_a_re <= ACC_W'(lanes[sel].re) + ROUND_BIAS;
        acc_a_im <= ACC_W'(lanes[sel].im) + ROUND_BIAS;
        acc_b_re <= '0;
        acc_b_im <= '0;
      end
    end
  end

  assign q_a_re = round_sat(acc_a_re);
  assign q_a_im = round_sat(acc_a_im);
  assign q_b_re = round_sat(acc_b_re);
  assign q_b_im = round_sat(acc_b_im);

  always_ff @(posedge clk) begin
    if (ctl.out_en) begin
      result.out_a_re  <= q_a_re[SMP_W-1:0];
      result.out_a_im  <= q_a_im[SMP_W-1:0];
      result.out_b_re  <= q_b_re[SMP_W-1:0];
      result.out_b_im  <= q_b_im[SMP_W-1:0];
      result.saturated <= q_a_re[SMP_W] | q_a_im[SMP_W] | q_b_re[SMP_W] | q_b_im[SMP_W];
    end
  end

endmodule

// ===== rtl/core/frequency_response_multiplier_top.sv =====
// Frequency response multiplier top level: coefficient table and bin filter pipeline.
// An apply beat passes the stages listed below, in order, before it shows on result.
// Throughput: one beat per cycle while result_ready does not hold the pipeline, set by
// the single table port of each lane and the registered lane multipliers; a load beat
// takes one pipeline slot, no result. Reset clears stage valid bits and the configuration
// registers and holds item_ready low; the table has no clearing pass.
`include "frequency_response_multiplier_top_assert.svh"

module frequency_response_multiplier_top
  import frm_pkg::*;
#(
  parameter int BINS = BINS_DEF,
  localparam int AW = $clog2(BINS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  frm_in_t               item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output frm_out_t              result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Pipeline stages, numbered from the input side:
  //   0, 1  bin wrap (quotient, then remainder) with the beat payload alongside
  //   2     table access in every lane (load beats write here and end)
  //   3, 4  lane multiply, then lane complex sums
  //   5, 6  merge with rounding bias, then saturation into the result register
  localparam int STAGES = 7;

  logic              jones_mode;
  logic [2:0]        filter_count;

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] valid_in;
  logic [STAGES-1:0] en;

  frm_in_t           s1_item, s2_item;
  logic [1:0]        s1_sel, s2_sel, s3_sel, s4_sel, s5_sel;
  frm_cplx_t         s3_a, s3_b;
  logic [1:0]        pol_sel;

  logic [AW-1:0]     addr;
  frm_lane_sum_t     lane_sum [SLOTS];
  logic [SLOTS-1:0]  lane_wr;
  frm_merge_ctl_t    merge_ctl;

  logic              load_retire;
  logic              b_zero;
  logic              sat_flag;
  logic              at_limit;

  // Configuration writes land directly; the user, not the block, keeps it idle then.
  always_ff @(posedge clk) begin
    if (rst) begin
      jones_mode   <= 1'b0;
      filter_count <= FILTER_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_JONES_MODE:   jones_mode   <= cfg_data[0];
        REG_FILTER_COUNT: filter_count <= cfg_data;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on, so bubbles are squeezed
  // out and a new beat is taken while a result waits at the output, if a stage is empty.
  always_comb begin
    en[STAGES-1] = !valid[STAGES-1] || result_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  always_comb begin
    valid_in    = valid << 1;
    valid_in[0] = item_valid;
    // Load beats retire at the table access stage.
    valid_in[2] = valid[1] && (s2_item.func == FUNC_APPLY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (en[k]) begin
          valid[k] <= valid_in[k];
        end
      end
    end
  end

  // No beat is taken while reset is held.
  assign item_ready   = en[0] && !rst;
  assign result_valid = valid[STAGES-1];

  // Scalar mode: a polarization at or above the filter count uses the first slot.
  assign pol_sel = (3'(item.pol) >= filter_count) ? 2'd0 : item.pol;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_item <= item;
      s1_sel  <= pol_sel;
    end
    if (en[1]) begin
      s2_item <= s1_item;
      s2_sel  <= s1_sel;
    end
    if (en[2]) begin
      s3_a   <= '{re: s2_item.a_re, im: s2_item.a_im};
      s3_b   <= '{re: s2_item.b_re, im: s2_item.b_im};
      s3_sel <= s2_sel;
    end
    if (en[3]) begin
      s4_sel <= s3_sel;
    end
    if (en[4]) begin
      s5_sel <= s4_sel;
    end
  end

  frm_wrap #(.BINS(BINS)) u_wrap (
    .clk  (clk),
    .en1  (en[0]),
    .en2  (en[1]),
    .bin  (item.bin),
    .addr (addr)
  );

  // One lane per slot. In Jones mode the f11 and f21 lanes take pol A and the
  // f22 and f12 lanes take pol B; in scalar mode every lane takes pol A.
  for (genvar g = 0; g < SLOTS; g++) begin : g_lane
    frm_lane_ctl_t lane_ctl;

    assign lane_wr[g] = valid[1] && en[2] && (s2_item.func == FUNC_LOAD)
                        && (s2_item.slot == 2'(g));

    assign lane_ctl = '{mem_en: en[2], wr_en: lane_wr[g], mul_en: en[3], sum_en: en[4]};

    frm_lane #(.BINS(BINS)) u_lane (
      .clk   (clk),
      .ctl   (lane_ctl),
      .addr  (addr),
      .wdata ({s2_item.a_re, s2_item.a_im}),
      .smp_a (s3_a),
      .smp_b (s3_b),
      .use_b (jones_mode && (g >= 2)),
      .sum   (lane_sum[g])
    );
  end

  assign merge_ctl = '{acc_en: en[5], out_en: en[6]};

  frm_merge u_merge (
    .clk    (clk),
    .ctl    (merge_ctl),
    .jones  (jones_mode),
    .sel    (s5_sel),
    .lanes  (lane_sum),
    .result (result)
  );

  assign load_retire = valid[1] && en[2] && (s2_item.func == FUNC_LOAD);
  assign b_zero      = (result.out_b_re == '0) && (result.out_b_im == '0);
  assign sat_flag    = result_valid && result.saturated;
  assign at_limit    = (result.out_a_re == 16'sh7FFF) || (result.out_a_re == -16'sh8000)
                       || (result.out_a_im == 16'sh7FFF) || (result.out_a_im == -16'sh8000)
                       || (result.out_b_re == 16'sh7FFF) || (result.out_b_re == -16'sh8000)
                       || (result.out_b_im == 16'sh7FFF) || (result.out_b_im == -16'sh8000);

  // A load beat leaving the wrap stages must not occupy the table access stage.
  `FRM_ASSERT_NEXT(a_load_no_result, load_retire, !valid[2], "load beat entered the result path")
  // A load writes exactly one slot.
  `FRM_ASSERT_NOW(a_one_lane_write, 1'b1, $onehot0(lane_wr), "more than one lane written")
  // Scalar results carry zero for pol B.
  `FRM_ASSERT_NOW(a_scalar_b_zero, result_valid && !jones_mode, b_zero, "pol B not zero in scalar mode")
  // A clipped result holds at least one component at a range limit.
  `FRM_ASSERT_NOW(a_sat_at_limit, sat_flag, at_limit, "saturated flag without a clipped component")

endmodule
